// ----- rtl/kdhe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdhe_pkg: shared types and constants for the keypad debounce block
// key state record, event record, register indexes, key map, ms reciprocal
// ----------------------------------------------------------------------------
package kdhe_pkg;

  localparam int ROW_COUNT = 4;
  localparam int COL_COUNT = 4;
  localparam int KEY_COUNT = 16;
  localparam int KEY_AW    = 4;

  localparam int DEB_W   = 20;
  localparam int HOLD_W  = 22;
  localparam int TIME_W  = 32;
  localparam int STAMP_W = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;

  localparam logic [DEB_W-1:0]  DEB_RESET  = 20'd50000;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 22'd500000;

  // floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
  localparam int RECIP_W  = 29;
  localparam int MS_SHIFT = 38;
  localparam logic [RECIP_W-1:0] MS_RECIP = 29'd274877907;
  localparam int PROD_W = TIME_W + RECIP_W;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED  = 2'd2,
    MODE_HELD     = 2'd3
  } key_mode_t;

  typedef enum logic [1:0] {
    KIND_PRESSED  = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_HOLD     = 2'd2
  } event_kind_t;

  typedef struct packed {
    key_mode_t          mode;
    logic [TIME_W-1:0]  since;
    logic               level;
  } key_state_t;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    event_kind_t        kind;
    logic [TIME_W-1:0]  now;
  } key_event_t;

  // row-major key map, index {row, col}
  localparam logic [7:0] KEY_MAP [KEY_COUNT] = '{
    8'h31, 8'h32, 8'h33, 8'h41,   // 1 2 3 A
    8'h34, 8'h35, 8'h36, 8'h42,   // 4 5 6 B
    8'h37, 8'h38, 8'h39, 8'h43,   // 7 8 9 C
    8'h2A, 8'h30, 8'h23, 8'h44    // * 0 # D
  };

endpackage

// ----- rtl/keypad_debounce_hold_events.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_debounce_hold_events: 4x4 keypad debounce and hold event detector
// per-key state machines kept in a small ram, one key sample per beat
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one key sample per beat (row, column, level, time in us)
//   out_* : pressed / released / hold events, kind on out_tuser
//   cfg_* : register writes (index 0 debounce time, index 1 hold time),
//           always ready, to be written only while the block is idle (not enforced)
// timing:
//   a sample is taken every cycle unless events back up; the ram read of one
//   sample overlaps the update and write-back of the previous one, same-key
//   samples are forwarded; from input beat to event beat: ram read, update,
//   ms stamp multiply, then output register
//   throughput is one sample per cycle while events do not back up, set by the single ram port pair
// reset:
//   registers return to 50000 / 500000 us, every key reads as idle and
//   released at once (per-entry valid bits, no clearing pass)
// stall:
//   a stalled event holds in the output register while the next event and
//   one more sample move up behind it; input ready drops only when an event
//   can go nowhere
// ----------------------------------------------------------------------------
module keypad_debounce_hold_events (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // key_row[1:0], key_col[3:2], key_down[4], now_us[36:5]
  // event beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // event_row[1:0], event_col[3:2], char_code[11:4],
                                   // stamp_ms[34:12]
  output logic [1:0]  out_tuser,   // event_kind[1:0]
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [kdhe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdhe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kdhe_pkg::*;

  // configuration
  logic [DEB_W-1:0]  deb_r;
  logic [HOLD_W-1:0] hold_r;
  logic [DEB_W-1:0]  cfg_deb;
  logic [HOLD_W-1:0] cfg_hold;

  assign cfg_ready = 1'b1;
  assign cfg_deb   = cfg_data[DEB_W-1:0];
  assign cfg_hold  = cfg_data[HOLD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= DEB_RESET;
      hold_r <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // zero debounce and hold not above debounce are ignored
      if (cfg_index == REG_DEBOUNCE && cfg_deb != '0) begin
        deb_r <= cfg_deb;
      end
      if (cfg_index == REG_HOLD && cfg_hold > HOLD_W'(deb_r)) begin
        hold_r <= cfg_hold;
      end
    end
  end

  // input fields
  logic [1:0]        in_row;
  logic [1:0]        in_col;
  logic              in_down;
  logic [TIME_W-1:0] in_now;
  logic              in_acc;
  logic              in_ok;

  assign in_row  = in_tdata[1:0];
  assign in_col  = in_tdata[3:2];
  assign in_down = in_tdata[4];
  assign in_now  = in_tdata[36:5];
  assign in_acc  = in_tvalid && in_tready;
  // positions outside the matrix are dropped without touching state
  assign in_ok   = ({1'b0, in_row} < 3'(ROW_COUNT)) && ({1'b0, in_col} < 3'(COL_COUNT));

  // update stage: holds the sample while its ram read returns
  logic              v1_r;
  logic [1:0]        row1_r;
  logic [1:0]        col1_r;
  logic              lvl1_r;
  logic [TIME_W-1:0] now1_r;
  logic              s1_go;

  key_state_t  cur_st;
  key_state_t  nxt_st;
  logic        fire;
  event_kind_t kind;
  logic        ev_ready;
  key_event_t  ev;

  // a sample without an event always leaves; one with an event waits for room
  assign s1_go     = v1_r && (!fire || ev_ready);
  assign in_tready = !v1_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= in_ok;
    end else if (s1_go) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row1_r <= in_row;
      col1_r <= in_col;
      lvl1_r <= in_down;
      now1_r <= in_now;
    end
  end

  kdhe_key_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc && in_ok),
    .rd_addr ({in_row, in_col}),
    .rd_data (cur_st),
    .wr_en   (s1_go),
    .wr_addr ({row1_r, col1_r}),
    .wr_data (nxt_st)
  );

  kdhe_key_update u_update (
    .cur           (cur_st),
    .level         (lvl1_r),
    .now           (now1_r),
    .debounce_time (deb_r),
    .hold_time     (hold_r),
    .nxt           (nxt_st),
    .fire          (fire),
    .kind          (kind)
  );

  always_comb begin
    ev.row  = row1_r;
    ev.col  = col1_r;
    ev.kind = kind;
    ev.now  = now1_r;
  end

  kdhe_event_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (v1_r && fire),
    .ev_ready   (ev_ready),
    .ev         (ev),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/kdhe_key_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdhe_key_store: per-key state memory
// 16-entry synchronous ram, registered read, per-entry valid bits and
// write-to-read forwarding for back-to-back samples of the same key
// ----------------------------------------------------------------------------
module kdhe_key_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [kdhe_pkg::KEY_AW-1:0] rd_addr,
  output kdhe_pkg::key_state_t        rd_data,
  input  logic                        wr_en,
  input  logic [kdhe_pkg::KEY_AW-1:0] wr_addr,
  input  kdhe_pkg::key_state_t        wr_data
);
  import kdhe_pkg::*;

  key_state_t             mem [KEY_COUNT];
  logic [KEY_COUNT-1:0]   vld_r;
  key_state_t             rd_q_r;
  logic                   rd_vld_r;
  logic                   byp_r;
  key_state_t             byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
        byp_r    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // never-written entries read as the reset state
  always_comb begin
    if (byp_r) begin
      rd_data = byp_data_r;
    end else if (rd_vld_r) begin
      rd_data = rd_q_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ----- rtl/kdhe_key_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdhe_key_update: per-key debounce / hold state machine step
// next state from the stored record and the new sample, plus event decode
// ----------------------------------------------------------------------------
module kdhe_key_update (
  input  kdhe_pkg::key_state_t              cur,
  input  logic                              level,
  input  logic [kdhe_pkg::TIME_W-1:0]       now,
  input  logic [kdhe_pkg::DEB_W-1:0]        debounce_time,
  input  logic [kdhe_pkg::HOLD_W-1:0]       hold_time,
  output kdhe_pkg::key_state_t              nxt,
  output logic                              fire,
  output kdhe_pkg::event_kind_t             kind
);
  import kdhe_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic              deb_done;
  logic              hold_done;
  logic              changed;

  assign elapsed   = now - cur.since;
  assign deb_done  = elapsed >= TIME_W'(debounce_time);
  assign hold_done = elapsed >= TIME_W'(hold_time);
  assign changed   = level != cur.level;

  // next state
  always_comb begin
    nxt = cur;
    if (changed) begin
      nxt.mode  = MODE_DEBOUNCE;
      nxt.since = now;
      nxt.level = level;
    end else begin
      unique case (cur.mode)
        MODE_DEBOUNCE: begin
          if (deb_done) begin
            if (cur.level) begin
              nxt.mode  = MODE_PRESSED;
              nxt.since = now;
            end else begin
              nxt.mode = MODE_IDLE;
            end
          end
        end
        MODE_PRESSED: begin
          if (!cur.level) begin
            nxt.mode  = MODE_DEBOUNCE;
            nxt.since = now;
          end else if (hold_done) begin
            nxt.mode = MODE_HELD;
          end
        end
        MODE_HELD: begin
          if (!cur.level) begin
            nxt.mode  = MODE_DEBOUNCE;
            nxt.since = now;
          end
        end
        MODE_IDLE: begin
          nxt = cur;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  // event decode
  always_comb begin
    fire = 1'b0;
    kind = KIND_PRESSED;
    if (!changed) begin
      unique case (cur.mode)
        MODE_DEBOUNCE: begin
          fire = deb_done;
          kind = cur.level ? KIND_PRESSED : KIND_RELEASED;
        end
        MODE_PRESSED: begin
          fire = cur.level && hold_done;
          kind = KIND_HOLD;
        end
        MODE_IDLE, MODE_HELD: begin
          fire = 1'b0;
        end
        default: begin
          fire = 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/kdhe_event_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdhe_event_out: event stamping and output register
// one stage for the us-to-ms reciprocal multiply, then the output beat register
// ----------------------------------------------------------------------------
module kdhe_event_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ev_valid,
  output logic                  ev_ready,
  input  kdhe_pkg::key_event_t  ev,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,
  output logic [1:0]            out_tuser
);
  import kdhe_pkg::*;

  logic              v2_r;
  key_event_t        ev2_r;
  logic              out_v_r;
  logic [1:0]        row_r;
  logic [1:0]        col_r;
  logic [7:0]        char_r;
  event_kind_t       kind_r;
  logic [STAMP_W-1:0] stamp_r;
  logic              rdy_o;
  logic [PROD_W-1:0] prod;

  assign rdy_o    = !out_v_r || out_tready;
  assign ev_ready = !v2_r || rdy_o;
  assign prod     = PROD_W'(ev2_r.now) * PROD_W'(MS_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ev_ready) begin
        v2_r <= ev_valid;
      end
      if (rdy_o) begin
        out_v_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && ev_valid) begin
      ev2_r <= ev;
    end
    if (rdy_o && v2_r) begin
      row_r   <= ev2_r.row;
      col_r   <= ev2_r.col;
      char_r  <= KEY_MAP[{ev2_r.row, ev2_r.col}];
      kind_r  <= ev2_r.kind;
      stamp_r <= prod[MS_SHIFT +: STAMP_W];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, stamp_r, char_r, col_r, row_r};
  assign out_tuser  = kind_r;

endmodule

// ----- bench/keypad_debounce_hold_events_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_debounce_hold_events_test: self-checking bench for the keypad block
// drives key samples on the input stream, predicts pressed / released / hold
// events with a per-key model of its own and checks every event beat in order
// ----------------------------------------------------------------------------
module keypad_debounce_hold_events_test;
  import kdhe_pkg::*;

  // cycles with no handshake at all before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  // quiet cycles after the last event (pipeline is 3 deep, plus slack)
  localparam int SETTLE_CYCLES = 8;
  localparam int SHOW_LIMIT = 10;

  // key characters, row-major, '1' in the top byte
  localparam logic [127:0] GLYPHS = "123A456B789C*0#D";

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,   // expectation from the predictor
    CHK_NONE  = 2'd1,   // typed in: no event
    CHK_EVENT = 2'd2    // typed in: the event given in the row
  } check_t;

  typedef struct packed {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [7:0]  glyph;
    event_kind_t kind;
    logic [22:0] stamp;
  } key_event_rec_t;

  typedef struct packed {
    logic [1:0]  row;
    logic [1:0]  col;
    logic        down;
    logic [31:0] now;
    check_t      chk;
    event_kind_t kind;
    logic [7:0]  glyph;
    logic [22:0] stamp;
  } key_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  keypad_debounce_hold_events dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state: per-key mode, time stamp and level, plus the two registers
  key_mode_t   pad_mode  [16];
  logic [31:0] pad_since [16];
  logic        pad_level [16];
  logic [19:0] deb_us;
  logic [21:0] hold_us;

  key_event_rec_t pending_events[$];
  key_beat_t      directed_rows[$];

  // stimulus shaping
  bit          idle_en;
  bit          pad_aim [16];   // level each key is heading for
  logic [3:0]  hot_keys [3];
  logic [31:0] clock_us;
  int          stall_left;
  int          err_cnt;
  int          quiet_cycles;

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // predictor: one key sample in, zero or one event out
  // -------------------------------------------------------------------------
  function automatic bit predict_event(input logic [1:0] r, input logic [1:0] c,
                                       input logic lvl, input logic [31:0] now,
                                       output key_event_rec_t ev);
    logic [3:0]  k;
    logic [31:0] elapsed;
    logic [31:0] ms;
    bit          fire;
    k       = {r, c};
    elapsed = now - pad_since[k];   // wraps modulo 2^32
    fire    = 1'b0;
    ms      = now / 32'd1000;
    ev.row   = r;
    ev.col   = c;
    ev.glyph = GLYPHS[8*(15-k) +: 8];
    ev.kind  = KIND_PRESSED;
    ev.stamp = ms[22:0];
    if (lvl != pad_level[k]) begin
      // any level change restarts debouncing
      pad_since[k] = now;
      pad_level[k] = lvl;
      pad_mode[k]  = MODE_DEBOUNCE;
    end else begin
      case (pad_mode[k])
        MODE_DEBOUNCE: begin
          if (elapsed >= {12'd0, deb_us}) begin
            fire = 1'b1;
            if (pad_level[k]) begin
              pad_mode[k]  = MODE_PRESSED;
              pad_since[k] = now;
              ev.kind      = KIND_PRESSED;
            end else begin
              pad_mode[k] = MODE_IDLE;
              ev.kind     = KIND_RELEASED;
            end
          end
        end
        MODE_PRESSED: begin
          if (!pad_level[k]) begin
            pad_mode[k]  = MODE_DEBOUNCE;
            pad_since[k] = now;
          end else if (elapsed >= {10'd0, hold_us}) begin
            pad_mode[k] = MODE_HELD;
            fire        = 1'b1;
            ev.kind     = KIND_HOLD;
          end
        end
        MODE_HELD: begin
          if (!pad_level[k]) begin
            pad_mode[k]  = MODE_DEBOUNCE;
            pad_since[k] = now;
          end
        end
        default: ;
      endcase
    end
    return fire;
  endfunction

  // -------------------------------------------------------------------------
  // input side: one key sample per beat, random gaps while idling is on
  // -------------------------------------------------------------------------
  task automatic put_key_beat(input key_beat_t b);
    key_event_rec_t ev;
    bit             fired;
    int             gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, b.now, b.down, b.col, b.row};
    do @(posedge clk); while (!in_tready);
    // beat taken: advance the predictor, queue what this beat must cause
    fired = predict_event(b.row, b.col, b.down, b.now, ev);
    case (b.chk)
      CHK_MODEL: if (fired) pending_events.push_back(ev);
      CHK_EVENT: begin
        ev.row   = b.row;
        ev.col   = b.col;
        ev.glyph = b.glyph;
        ev.kind  = b.kind;
        ev.stamp = b.stamp;
        pending_events.push_back(ev);
      end
      default: ;
    endcase
  endtask

  function automatic void add_row(input logic [1:0] r, input logic [1:0] c,
                                  input logic d, input logic [31:0] now,
                                  input check_t chk, input event_kind_t kind,
                                  input logic [7:0] glyph, input logic [22:0] stamp);
    key_beat_t b;
    b.row   = r;
    b.col   = c;
    b.down  = d;
    b.now   = now;
    b.chk   = chk;
    b.kind  = kind;
    b.glyph = glyph;
    b.stamp = stamp;
    directed_rows.push_back(b);
  endfunction

  // register write on the config channel; the predictor copy follows the
  // block's rules: zero debounce and a hold not above debounce are dropped
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [21:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE: if (data[19:0] != 20'd0) deb_us = data[19:0];
      REG_HOLD:     if (data > {2'b00, deb_us}) hold_us = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // let every expected event come out, then wait SETTLE_CYCLES so that samples
  // that cause no event can leave the pipeline
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // random samples: mostly well-formed key activity on a few hot keys, with
  // exact debounce / hold boundaries, bounce noise and wild time jumps
  // -------------------------------------------------------------------------
  task automatic run_random(input int count);
    key_beat_t   b;
    logic [3:0]  k;
    logic [31:0] offs;
    int          sel;
    for (int j = 0; j < 3; j++) hot_keys[j] = 4'($urandom_range(0, 15));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) k = hot_keys[$urandom_range(0, 2)];
      else k = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) pad_aim[k] = !pad_aim[k];
      b.down = pad_aim[k];
      if ($urandom_range(0, 6) == 0) b.down = !b.down;   // contact bounce
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        // free-running time moves on
        case ($urandom_range(0, 3))
          0: offs = 32'd0;
          1: offs = $urandom_range(1, deb_us);
          2: offs = {12'd0, deb_us} + $urandom_range(0, 3);
          default: offs = $urandom_range(1, hold_us);
        endcase
        clock_us = clock_us + offs;
      end else if (sel < 85) begin
        // land on or right next to a threshold of this key
        case ($urandom_range(0, 5))
          0: offs = {12'd0, deb_us} - 32'd1;
          1: offs = {12'd0, deb_us};
          2: offs = {12'd0, deb_us} + 32'd1;
          3: offs = {10'd0, hold_us} - 32'd1;
          4: offs = {10'd0, hold_us};
          default: offs = {10'd0, hold_us} + 32'd1;
        endcase
        clock_us = pad_since[k] + offs;
      end else begin
        clock_us = $urandom;
      end
      b.row   = k[3:2];
      b.col   = k[1:0];
      b.now   = clock_us;
      b.chk   = CHK_MODEL;
      b.kind  = KIND_PRESSED;
      b.glyph = 8'h00;
      b.stamp = 23'd0;
      put_key_beat(b);
    end
  endtask

  // -------------------------------------------------------------------------
  // output side: random stall bursts while idling is on
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!idle_en) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // event checker: each event beat against the oldest expectation
  always @(posedge clk) begin
    key_event_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOW_LIMIT)
          $display("unexpected event beat: row %0d col %0d char %h kind %0d ms %0d",
                   out_tdata[1:0], out_tdata[3:2], out_tdata[11:4], out_tuser,
                   out_tdata[34:12]);
      end else begin
        want = pending_events.pop_front();
        if (out_tdata[1:0] !== want.row || out_tdata[3:2] !== want.col ||
            out_tdata[11:4] !== want.glyph || out_tuser !== want.kind ||
            out_tdata[34:12] !== want.stamp) begin
          err_cnt++;
          if (err_cnt <= SHOW_LIMIT)
            $display("event mismatch: expected row %0d col %0d char %h kind %0d ms %0d, got row %0d col %0d char %h kind %0d ms %0d",
                     want.row, want.col, want.glyph, want.kind, want.stamp,
                     out_tdata[1:0], out_tdata[3:2], out_tdata[11:4], out_tuser,
                     out_tdata[34:12]);
        end
      end
    end
  end

  // hang detection: no beat on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DEBOUNCE;
    cfg_data     = '0;
    idle_en      = 1'b1;
    stall_left   = 0;
    err_cnt      = 0;
    quiet_cycles = 0;
    clock_us     = 32'h0100_0000;
    deb_us       = 20'd50000;
    hold_us      = 22'd500000;
    for (int i = 0; i < 16; i++) begin
      pad_mode[i]  = MODE_IDLE;
      pad_since[i] = 32'd0;
      pad_level[i] = 1'b0;
      pad_aim[i]   = 1'b0;
    end

    // directed rows at the reset register values (50000 / 500000 us)
    // key '1': reset state, debounce edge, press, hold edge, hold, release
    add_row(2'd0, 2'd0, 1'b0, 32'd0,      CHK_NONE,  KIND_PRESSED,  "1", 23'd0);
    add_row(2'd0, 2'd0, 1'b1, 32'd1000,   CHK_NONE,  KIND_PRESSED,  "1", 23'd0);
    add_row(2'd0, 2'd0, 1'b1, 32'd50999,  CHK_NONE,  KIND_PRESSED,  "1", 23'd0);
    add_row(2'd0, 2'd0, 1'b1, 32'd51000,  CHK_EVENT, KIND_PRESSED,  "1", 23'd51);
    add_row(2'd0, 2'd0, 1'b1, 32'd550999, CHK_NONE,  KIND_PRESSED,  "1", 23'd0);
    add_row(2'd0, 2'd0, 1'b1, 32'd551000, CHK_EVENT, KIND_HOLD,     "1", 23'd551);
    add_row(2'd0, 2'd0, 1'b1, 32'd600000, CHK_NONE,  KIND_PRESSED,  "1", 23'd0);
    add_row(2'd0, 2'd0, 1'b0, 32'd700000, CHK_NONE,  KIND_PRESSED,  "1", 23'd0);
    add_row(2'd0, 2'd0, 1'b0, 32'd750000, CHK_EVENT, KIND_RELEASED, "1", 23'd750);
    // key 'D': debounce across the time wrap
    add_row(2'd3, 2'd3, 1'b1, 32'hFFFF_FFF0, CHK_NONE,  KIND_PRESSED, "D", 23'd0);
    add_row(2'd3, 2'd3, 1'b1, 32'h0000_C340, CHK_EVENT, KIND_PRESSED, "D", 23'd49);
    // key '*': press stamped at the largest time
    add_row(2'd3, 2'd0, 1'b1, 32'hFFFF_3CAF, CHK_NONE,  KIND_PRESSED, "*", 23'd0);
    add_row(2'd3, 2'd0, 1'b1, 32'hFFFF_FFFF, CHK_EVENT, KIND_PRESSED, "*", 23'd4294967);
    // key '6': bounce back to released, then a released event with no press
    add_row(2'd1, 2'd2, 1'b1, 32'd100,    CHK_MODEL, KIND_PRESSED, "6", 23'd0);
    add_row(2'd1, 2'd2, 1'b0, 32'd200,    CHK_MODEL, KIND_PRESSED, "6", 23'd0);
    add_row(2'd1, 2'd2, 1'b0, 32'd50200,  CHK_MODEL, KIND_PRESSED, "6", 23'd0);
    // key '8': press, let go before the hold time
    add_row(2'd2, 2'd1, 1'b1, 32'h7FFF_FFFF, CHK_MODEL, KIND_PRESSED, "8", 23'd0);
    add_row(2'd2, 2'd1, 1'b1, 32'h8000_C34F, CHK_MODEL, KIND_PRESSED, "8", 23'd0);
    add_row(2'd2, 2'd1, 1'b0, 32'h8001_0000, CHK_MODEL, KIND_PRESSED, "8", 23'd0);
    add_row(2'd2, 2'd1, 1'b0, 32'h8002_0000, CHK_MODEL, KIND_PRESSED, "8", 23'd0);
    // key 'A': held straight through the hold time
    add_row(2'd0, 2'd3, 1'b1, 32'd10,     CHK_MODEL, KIND_PRESSED, "A", 23'd0);
    add_row(2'd0, 2'd3, 1'b1, 32'd60000,  CHK_MODEL, KIND_PRESSED, "A", 23'd0);
    add_row(2'd0, 2'd3, 1'b1, 32'd900000, CHK_MODEL, KIND_PRESSED, "A", 23'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) put_key_beat(directed_rows[i]);
    drain();

    // writes that must be dropped, then the smallest legal pair
    cfg_write(REG_DEBOUNCE, 22'd0);
    cfg_write(REG_HOLD, 22'd50000);
    cfg_write(REG_DEBOUNCE, 22'd1);
    cfg_write(REG_HOLD, 22'd2);
    run_random(90);
    drain();

    // values near the top of the register widths
    cfg_write(REG_DEBOUNCE, 22'd1000000);
    cfg_write(REG_HOLD, 22'd4000000);
    run_random(90);
    drain();

    // all register bits set
    cfg_write(REG_DEBOUNCE, 22'h0F_FFFF);
    cfg_write(REG_HOLD, 22'h3F_FFFF);
    run_random(90);
    drain();

    // short debounce, a hold write below it is dropped, then a real one
    cfg_write(REG_DEBOUNCE, 22'd300);
    cfg_write(REG_HOLD, 22'd200);
    cfg_write(REG_HOLD, 22'd5000);
    run_random(90);
    drain();

    // random pair, full rate on both sides to the end
    cfg_write(REG_DEBOUNCE, 22'($urandom_range(1, 2000)));
    cfg_write(REG_HOLD, {2'b00, deb_us} + 22'($urandom_range(1, 20000)));
    idle_en = 1'b0;
    run_random(90);
    drain();

    if (err_cnt == 0 && pending_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
